### rtl/core/bcdrtc_pkg.sv
// Package: shared commands, controller/datapath command and status types, mask table, month lengths, BCD split.
package bcdrtc_pkg;

  localparam int unsigned TicksPerSecond = 16;
  localparam int unsigned RegsPerBlock   = 13;
  localparam int unsigned NumRegs        = 4 * RegsPerBlock;
  localparam int unsigned RegIdxW        = $clog2(NumRegs);

  typedef enum logic [1:0] {
    CMD_LATCH = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  localparam logic [3:0] PortMode  = 4'd13;
  localparam logic [3:0] PortTest  = 4'd14;
  localparam logic [3:0] PortReset = 4'd15;

  // Controller to datapath
  typedef struct packed {
    logic latch;       // load address latch
    logic write;       // data write, first step (store nibble)
    logic reload;      // regs to counters
    logic tick;        // advance counters
    logic day_step;    // one month-length subtraction if due
    logic year_step;   // year carry and wrap
    logic publish;     // counters to regs
    logic read;        // capture read byte
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic day_over;    // day count still past month end
    logic blk_low;     // current block is 0 or 1
  } dp_sts_t;

  function automatic logic [3:0] reg_mask(input logic [1:0] blk, input logic [3:0] port);
    logic [3:0] m;
    m = 4'hF;
    if (blk == 2'd0) begin
      case (port)
        4'd1, 4'd3, 4'd6: m = 4'h7;
        4'd5, 4'd8:       m = 4'h3;
        4'd10:            m = 4'h1;
        default:          m = 4'hF;
      endcase
    end else if (blk == 2'd1) begin
      case (port)
        4'd0, 4'd1, 4'd9, 4'd12: m = 4'h0;
        4'd3, 4'd6:              m = 4'h7;
        4'd5, 4'd8, 4'd11:       m = 4'h3;
        4'd10:                   m = 4'h1;
        default:                 m = 4'hF;
      endcase
    end
    return m;
  endfunction

  function automatic logic [4:0] days_of(input logic [3:0] month, input logic [1:0] leap);
    logic [4:0] d;
    case (month)
      4'd1:                    d = (leap == 2'd0) ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

  // Split a value below 100 into tens and units; tens by reciprocal multiply
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] p;
    logic [3:0]  t;
    logic [6:0]  u;
    p = 15'(v) * 15'd205;
    t = p[14:11];
    u = v - 7'(t) * 7'd10;
    return {t, u[3:0]};
  endfunction

endpackage

### rtl/core/bcd_real_time_clock_registers_unit.sv
// Top level: nibble-wide BCD real-time clock with alarm and RAM blocks.
// Steps: a latch loads the address latch; a read registers the byte into tdata; a write stores the nibble, then
// reloads the counters if block 0 or 1 is selected. Tick: advance, then month-end subtractions while due, year
// carry, publish. One word at a time; a word is taken only when the step sequencer is idle. A pending read
// result holds off input unless it is taken in the same cycle.
// Reset: async active low; clock starts at epoch, mode 8, block 2 register 0 = 0xA.
module bcd_real_time_clock_registers_unit #(
  parameter int unsigned TicksPerSecond = bcdrtc_pkg::TicksPerSecond
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [1:0] command, [5:2] write_value, [10] chip_enabled
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o   // [7:0] read_data
);

  bcdrtc_pkg::dp_cmd_t cmd;
  bcdrtc_pkg::dp_sts_t sts;

  bcdrtc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tdata_i[1:0]),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bcdrtc_dp #(.TicksPerSecond(TicksPerSecond)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i  (cmd),
    .val_i  (s_axis_tdata_i[5:2]),
    .en_i   (s_axis_tdata_i[10]),
    .sts_o  (sts),
    .rdata_o(m_axis_tdata_o)
  );

endmodule

### rtl/core/bcdrtc_dp.sv
// Datapath: register file, counters, calendar arithmetic and read byte.
module bcdrtc_dp #(
  parameter int unsigned TicksPerSecond = bcdrtc_pkg::TicksPerSecond
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bcdrtc_pkg::dp_cmd_t cmd_i,
  input  logic [3:0]          val_i,
  input  logic                en_i,
  output bcdrtc_pkg::dp_sts_t sts_o,
  output logic [7:0]          rdata_o
);

  localparam int unsigned FracW = $clog2(TicksPerSecond + 1);
  localparam int unsigned R     = bcdrtc_pkg::RegsPerBlock;

  // Blocks 0 and 1 (time and alarm) and blocks 2 and 3 (RAM) held apart
  logic [3:0] rf_q [2 * R];
  logic [3:0] ram_q [2 * R];
  logic [3:0] addr_q, mode_q, test_q;
  logic [FracW-1:0] frac_q;
  logic [6:0] sec_q, min_q;
  logic [7:0] year_q;
  logic [5:0] hour_q, day_q;
  logic [3:0] wday_q;
  logic [4:0] mon_q;
  logic [1:0] leap_q;
  logic       day_due_q;
  logic [7:0] rdata_q;

  logic [1:0] blk;
  logic       h24;
  logic [4:0] mon_mod;
  logic [4:0] mdays;

  assign blk     = mode_q[1:0];
  assign h24     = rf_q[R + 10] != 4'd0;
  assign mon_mod = (mon_q >= 5'd24) ? mon_q - 5'd24 :
                   (mon_q >= 5'd12) ? mon_q - 5'd12 : mon_q;
  assign mdays   = bcdrtc_pkg::days_of(mon_mod[3:0], leap_q);
  // Month-end loop only runs after a day carry
  assign sts_o.day_over = day_due_q && ({1'b0, day_q} >= {2'b0, mdays});
  assign sts_o.blk_low  = !blk[1];
  assign rdata_o = rdata_q;

  function automatic logic [7:0] pair(input logic [3:0] lo, input logic [3:0] hi);
    return 8'({4'b0, lo} + 8'(hi) * 8'd10);
  endfunction

  // Tick arithmetic
  logic [FracW-1:0] frac_n;
  logic [6:0] sec_n, min_n, hour_n;
  logic c_sec, c_min, c_hour, c_day;
  always_comb begin
    frac_n = frac_q + FracW'(mode_q[3]);
    c_sec  = test_q[0] || (frac_n >= FracW'(TicksPerSecond));
    sec_n  = sec_q + 7'(c_sec);
    c_min  = test_q[1] || (sec_n >= 7'd60);
    min_n  = min_q + 7'(c_min);
    c_hour = min_n >= 7'd60;
    hour_n = {1'b0, hour_q} + 7'(c_hour);
    c_day  = test_q[2] || (hour_n >= 7'd24);
  end

  // Year carry: forced, or one per twelve months
  logic [1:0] c_year;
  logic [7:0] year_n;
  assign c_year = test_q[3] ? 2'd1 : (mon_q >= 5'd24) ? 2'd2 : (mon_q >= 5'd12) ? 2'd1 : 2'd0;
  assign year_n = year_q + 8'(c_year);

  // Reload terms
  logic [7:0] p_hr, p_day, p_mon;
  assign p_hr  = pair(rf_q[4], rf_q[5]);
  assign p_day = pair(rf_q[7], rf_q[8]);
  assign p_mon = pair(rf_q[9], rf_q[10]);

  logic [6:0] h12;
  logic [7:0] bs, bm, bh, bd, bmo, by;
  always_comb begin
    h12 = {1'b0, hour_q};
    if (!h24 && hour_q >= 6'd12) h12 = {1'b0, hour_q} + 7'd8;
    bs  = bcdrtc_pkg::to_bcd(sec_q);
    bm  = bcdrtc_pkg::to_bcd(min_q);
    bh  = bcdrtc_pkg::to_bcd(h12);
    bd  = bcdrtc_pkg::to_bcd({1'b0, day_q} + 7'd1);
    bmo = bcdrtc_pkg::to_bcd({2'b0, mon_q} + 7'd1);
    by  = bcdrtc_pkg::to_bcd(year_q[6:0]);
  end

  // Index within the selected pair of blocks
  logic [4:0] lidx;
  assign lidx = 5'(blk[0]) * 5'(R) + {1'b0, addr_q};

  // Control registers and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0; mode_q <= 4'h8; test_q <= '0; frac_q <= '0;
      sec_q <= '0; min_q <= '0; hour_q <= '0; wday_q <= 4'd5;
      day_q <= '0; mon_q <= '0; year_q <= 8'd8; leap_q <= '0;
      day_due_q <= 1'b0;
    end else begin
      if (cmd_i.latch && en_i) addr_q <= val_i;
      if (cmd_i.write && en_i) begin
        if (addr_q == bcdrtc_pkg::PortMode) mode_q <= val_i;
        if (addr_q == bcdrtc_pkg::PortTest) test_q <= val_i;
        if (addr_q == bcdrtc_pkg::PortReset && val_i[1]) frac_q <= '0;
      end
      if (cmd_i.reload) begin
        sec_q  <= 7'(pair(rf_q[0], rf_q[1]));
        min_q  <= 7'(pair(rf_q[2], rf_q[3]));
        hour_q <= (!h24 && p_hr >= 8'd20) ? 6'(p_hr - 8'd8) : p_hr[5:0];
        wday_q <= rf_q[6];
        day_q  <= (p_day != 8'd0) ? 6'(p_day - 8'd1) : 6'd0;
        mon_q  <= (p_mon != 8'd0) ? 5'(p_mon - 8'd1) : 5'd0;
        year_q <= pair(rf_q[11], rf_q[12]);
        leap_q <= rf_q[R + 11][1:0];
      end
      if (cmd_i.tick) begin
        frac_q <= (frac_n >= FracW'(TicksPerSecond)) ? frac_n - FracW'(TicksPerSecond) : frac_n;
        sec_q  <= (sec_n >= 7'd60) ? sec_n - 7'd60 : sec_n;
        min_q  <= (min_n >= 7'd60) ? min_n - 7'd60 : min_n;
        hour_q <= (hour_n >= 7'd24) ? 6'(hour_n - 7'd24) : hour_n[5:0];
        day_due_q <= c_day;
        if (c_day) begin
          day_q  <= day_q + 6'd1;
          wday_q <= ((wday_q + 4'd1) >= 4'd7) ? wday_q + 4'd1 - 4'd7 : wday_q + 4'd1;
        end else if (wday_q >= 4'd7) begin
          wday_q <= wday_q - 4'd7;
        end
      end
      if (cmd_i.day_step && sts_o.day_over) begin
        day_q <= day_q - {1'b0, mdays};
        mon_q <= mon_q + 5'd1;
      end
      if (cmd_i.year_step) begin
        year_q <= (year_n >= 8'd100) ? year_n - 8'd100 : year_n;
        leap_q <= leap_q + c_year;
        mon_q  <= mon_mod;
      end
    end
  end

  // Register file: reset image, writes and time publication
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2 * R; i++) begin
        rf_q[i]  <= 4'd0;
        ram_q[i] <= 4'd0;
      end
      ram_q[0] <= 4'hA;
      rf_q[6]  <= 4'd5;
      rf_q[7]  <= 4'd1;
      rf_q[9]  <= 4'd1;
      rf_q[11] <= 4'd8;
    end else begin
      if (cmd_i.write && en_i) begin
        if (addr_q == bcdrtc_pkg::PortReset) begin
          if (val_i[0]) for (int i = 2; i < 9; i++) rf_q[R + i] <= 4'd0;
        end else if (addr_q < bcdrtc_pkg::PortMode) begin
          if (blk[1]) ram_q[lidx] <= val_i & bcdrtc_pkg::reg_mask(blk, addr_q);
          else        rf_q[lidx]  <= val_i & bcdrtc_pkg::reg_mask(blk, addr_q);
        end
      end
      if (cmd_i.publish) begin
        rf_q[0] <= bs[3:0];  rf_q[1] <= bs[7:4];
        rf_q[2] <= bm[3:0];  rf_q[3] <= bm[7:4];
        rf_q[4] <= bh[3:0];  rf_q[5] <= bh[7:4];
        rf_q[6] <= wday_q;
        rf_q[7] <= bd[3:0];  rf_q[8] <= bd[7:4];
        rf_q[9] <= bmo[3:0]; rf_q[10] <= bmo[7:4];
        rf_q[11] <= by[3:0]; rf_q[12] <= by[7:4];
        rf_q[R + 11] <= {2'b0, leap_q};
      end
    end
  end

  // Read byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      if (!en_i)                               rdata_q <= 8'hFF;
      else if (addr_q == bcdrtc_pkg::PortMode) rdata_q <= {4'hF, mode_q};
      else if (addr_q > bcdrtc_pkg::PortMode)  rdata_q <= 8'hFF;
      else if (blk[1]) rdata_q <= {4'hF, ram_q[lidx] & bcdrtc_pkg::reg_mask(blk, addr_q)};
      else rdata_q <= {4'hF, rf_q[lidx] & bcdrtc_pkg::reg_mask(blk, addr_q)};
    end
  end

endmodule

### rtl/core/bcdrtc_ctrl.sv
// Controller: sequences each word through the datapath and runs the handshake.
module bcdrtc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          in_cmd_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bcdrtc_pkg::dp_cmd_t cmd_o,
  input  bcdrtc_pkg::dp_sts_t sts_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_RELOAD, S_DAYS, S_YEAR, S_PUB
  } state_e;

  state_e state_q;
  logic   acc;
  logic   ovalid_q;

  // A pending result may leave in the same cycle a new word comes in
  assign in_ready_o  = (state_q == S_IDLE) && (!ovalid_q || out_ready_i);
  assign acc         = in_valid_i && in_ready_o;
  assign out_valid_o = ovalid_q;

  always_comb begin
    cmd_o = '0;
    if (acc) begin
      unique case (bcdrtc_pkg::cmd_e'(in_cmd_i))
        bcdrtc_pkg::CMD_LATCH: cmd_o.latch = 1'b1;
        bcdrtc_pkg::CMD_WRITE: cmd_o.write = 1'b1;
        bcdrtc_pkg::CMD_READ:  cmd_o.read  = 1'b1;
        bcdrtc_pkg::CMD_TICK:  cmd_o.tick  = 1'b1;
        default: ;
      endcase
    end
    unique case (state_q)
      S_RELOAD: cmd_o.reload    = sts_i.blk_low;
      S_DAYS:   cmd_o.day_step  = 1'b1;
      S_YEAR:   cmd_o.year_step = 1'b1;
      S_PUB:    cmd_o.publish   = 1'b1;
      default: ;
    endcase
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: if (acc) begin
          unique case (bcdrtc_pkg::cmd_e'(in_cmd_i))
            bcdrtc_pkg::CMD_WRITE: state_q <= S_RELOAD;
            bcdrtc_pkg::CMD_READ:  ovalid_q <= 1'b1;
            bcdrtc_pkg::CMD_TICK:  state_q <= S_DAYS;
            default: ;
          endcase
        end
        S_RELOAD: state_q <= S_IDLE;
        S_DAYS:   if (!sts_i.day_over) state_q <= S_YEAR;
        S_YEAR:   state_q <= S_PUB;
        S_PUB:    state_q <= S_IDLE;
        default:  state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/bcdrtc_chk.sv
// Port checker for the clock unit, bound to the top level.
module bcdrtc_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic [15:0] s_axis_tdata_i,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  // A pending result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result dropped");

  // A read word gives a result next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] == bcdrtc_pkg::CMD_READ
    |=> m_axis_tvalid_o)
    else $error("read lost");

  // Non-read words give no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] != bcdrtc_pkg::CMD_READ
    |=> !m_axis_tvalid_o)
    else $error("result invented");

  // Disabled read returns all ones
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tdata_i[1:0] == bcdrtc_pkg::CMD_READ &&
    !s_axis_tdata_i[10] |=> m_axis_tdata_o == 8'hFF)
    else $error("disabled read");

  // High nibble of every result is set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[7:4] == 4'hF)
    else $error("high nibble");

endmodule

bind bcd_real_time_clock_registers_unit bcdrtc_chk u_chk (.*);
